/* sv/ilo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ilo_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CMD_W = 3;
	localparam int POS_W = 8;
	localparam int DATA_W = 32;
	localparam int ST_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_HEAD   = 3'd2,
		CMD_TAIL   = 3'd3,
		CMD_DELETE = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// shift control broadcast to every cell
	typedef struct packed {
		logic ins;  // open a slot at pos, later entries move toward the tail
		logic del;  // close the slot at pos, later entries move toward the head
	} shift_ctl_t;

endpackage

`default_nettype wire

/* sv/ilo_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilo_cell #(
	parameter int IDX = 0,
	parameter int PW = 8
) (
	input  wire                             clk,
	input  wire ilo_pkg::shift_ctl_t        ctl,
	input  wire [PW-1:0]                    pos,
	input  wire [ilo_pkg::DATA_W-1:0]       value,
	input  wire [ilo_pkg::DATA_W-1:0]       left,
	input  wire [ilo_pkg::DATA_W-1:0]       right,
	output logic [ilo_pkg::DATA_W-1:0]      data,
	output logic [ilo_pkg::DATA_W-1:0]      hit
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [ilo_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX == pos) begin
				data_q <= value;
			end else if (MY_IDX > pos) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (MY_IDX >= pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	// masked read, the top level ORs all cells together
	assign hit = (MY_IDX == pos) ? data_q : '0;

endmodule

`default_nettype wire

/* sv/indexed_ordered_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   cmd, position, item_value
// out      out  out_valid / out_stall read_value, status, length_after
//
// One command per cycle when not stalled: the whole row of cells shifts in the
// cycle the command is taken, and the result enters the output register with it.
// Get reads the cell at the position through an AND-OR across the row.
// Reset clears the length and the output valid; cell contents are undefined
// until written and need no clearing.
// A held result stalls the input: in_stall follows out_valid & out_stall.

module indexed_ordered_list #(
	parameter int CAPACITY = ilo_pkg::CAPACITY_DEF,
	parameter int LEN_W = $clog2(CAPACITY + 1)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire [ilo_pkg::CMD_W-1:0]            cmd,
	input  wire [ilo_pkg::POS_W-1:0]            position,
	input  wire signed [ilo_pkg::DATA_W-1:0]    item_value,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [ilo_pkg::DATA_W-1:0]   read_value,
	output logic [ilo_pkg::ST_W-1:0]            status,
	output logic [LEN_W-1:0]                    length_after
);

	// common compare width for positions, lengths and cell indexes
	localparam int PW = (LEN_W > ilo_pkg::POS_W) ? LEN_W : ilo_pkg::POS_W;
	localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

	logic                        in_accept;
	logic [LEN_W-1:0]            len_q;
	logic [PW-1:0]               pos_x;
	logic [PW-1:0]               len_x;
	logic [PW-1:0]               eff_pos;
	ilo_pkg::shift_ctl_t         ctl;
	ilo_pkg::shift_ctl_t         ctl_gated;
	ilo_pkg::status_t            st;
	logic [ilo_pkg::DATA_W-1:0]  rd;
	logic [ilo_pkg::DATA_W-1:0]  rd_or;
	logic [LEN_W-1:0]            len_d;

	logic [ilo_pkg::DATA_W-1:0]  cell_data [CAPACITY];
	logic [ilo_pkg::DATA_W-1:0]  cell_hit  [CAPACITY];

	logic                                 out_valid_q;
	logic [ilo_pkg::DATA_W-1:0]           read_value_q;
	ilo_pkg::status_t                     status_q;
	logic [LEN_W-1:0]                     length_after_q;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	assign pos_x = PW'(position);
	assign len_x = PW'(len_q);

	// command decode: range check before full check, as inserts require
	always_comb begin
		ctl     = '0;
		st      = ilo_pkg::ST_DONE;
		eff_pos = pos_x;
		rd      = '0;
		case (ilo_pkg::cmd_t'(cmd))
			ilo_pkg::CMD_GET: begin
				if (pos_x < len_x) begin
					rd = rd_or;
				end else begin
					rd = '1;
					st = ilo_pkg::ST_RANGE;
				end
			end
			ilo_pkg::CMD_INSERT: begin
				if (pos_x > len_x) begin
					st = ilo_pkg::ST_RANGE;
				end else if (len_x == CAP_X) begin
					st = ilo_pkg::ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			ilo_pkg::CMD_HEAD: begin
				eff_pos = '0;
				if (len_x == CAP_X) begin
					st = ilo_pkg::ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			ilo_pkg::CMD_TAIL: begin
				eff_pos = len_x;
				if (len_x == CAP_X) begin
					st = ilo_pkg::ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			ilo_pkg::CMD_DELETE: begin
				if (pos_x < len_x) begin
					ctl.del = 1'b1;
				end else begin
					st = ilo_pkg::ST_RANGE;
				end
			end
			default: begin
				// unknown command: no change, zero result
			end
		endcase
	end

	assign ctl_gated.ins = ctl.ins & in_accept;
	assign ctl_gated.del = ctl.del & in_accept;

	always_comb begin
		if (ctl.ins) begin
			len_d = len_q + LEN_W'(1);
		end else if (ctl.del) begin
			len_d = len_q - LEN_W'(1);
		end else begin
			len_d = len_q;
		end
	end

	// row of cells; neighbor taps feed the shift in either direction
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [ilo_pkg::DATA_W-1:0] left_w;
		logic [ilo_pkg::DATA_W-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = item_value;
		end else begin : g_mid_l
			assign left_w = cell_data[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[k];
		end else begin : g_mid_r
			assign right_w = cell_data[k+1];
		end

		ilo_cell #(
			.IDX (k),
			.PW  (PW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl_gated),
			.pos   (eff_pos),
			.value (item_value),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[k]),
			.hit   (cell_hit[k])
		);
	end

	// at most one cell hits, so OR of the masked words is the read
	always_comb begin
		rd_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_or = rd_or | cell_hit[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				len_q       <= len_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			read_value_q   <= rd;
			status_q       <= st;
			length_after_q <= len_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign status       = status_q;
	assign length_after = length_after_q;

	// length never runs past the row of cells
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length exceeds capacity");

	// length moves only with a taken command
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(len_q))
		else $error("list length changed without a transfer");

	// a taken command always leaves a result in the output register
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q && (length_after_q == len_q))
		else $error("result missing or length mismatch");

	// a full status is only reported on a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ilo_pkg::ST_FULL) |->
			(length_after_q == LEN_W'(CAPACITY)))
		else $error("full status on a list that is not full");

endmodule

`default_nettype wire

/* tb/list_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the ordered list, keeps a shadow copy of the list,
// and checks every result transfer against the oldest prediction.
module list_checker import ilo_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int LEN_W = $clog2(CAPACITY + 1)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_stall,
	input  wire [CMD_W-1:0]           cmd,
	input  wire [POS_W-1:0]           position,
	input  wire signed [DATA_W-1:0]   item_value,
	input  wire                       out_valid,
	input  wire                       out_stall,
	input  wire signed [DATA_W-1:0]   read_value,
	input  wire [ST_W-1:0]            status,
	input  wire [LEN_W-1:0]           length_after,
	output int                        errors,
	output int                        pending,
	output int                        list_len
);

	typedef struct packed {
		logic signed [DATA_W-1:0] rd;
		status_t                  st;
		logic [LEN_W-1:0]         len;
	} list_result_t;

	logic signed [DATA_W-1:0] entries[$];
	list_result_t             owed_results[$];

	initial begin
		errors = 0;
		pending = 0;
		list_len = 0;
	end

	function automatic status_t place_entry(int at, logic signed [DATA_W-1:0] v);
		// range check wins over the full check
		if (at > entries.size())
			return ST_RANGE;
		if (entries.size() >= CAPACITY)
			return ST_FULL;
		entries.insert(at, v);
		return ST_DONE;
	endfunction

	function automatic list_result_t apply_command(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
			logic signed [DATA_W-1:0] v);
		list_result_t r;
		r.rd = '0;
		r.st = ST_DONE;
		case (c)
			CMD_GET: begin
				if (p < entries.size()) begin
					r.rd = entries[p];
				end else begin
					r.rd = -1;
					r.st = ST_RANGE;
				end
			end
			CMD_INSERT: r.st = place_entry(p, v);
			CMD_HEAD:   r.st = place_entry(0, v);
			CMD_TAIL:   r.st = place_entry(entries.size(), v);
			CMD_DELETE: begin
				if (p < entries.size())
					entries.delete(p);
				else
					r.st = ST_RANGE;
			end
			default: ;  // unused codes leave the list alone
		endcase
		r.len = LEN_W'(entries.size());
		return r;
	endfunction

	// Sampled mid-cycle: everything is settled, and each handshake seen here
	// completes at the following rising edge.
	always @(negedge clk) begin : watch
		list_result_t want;
		if (!arst_n) begin
			entries.delete();
			owed_results.delete();
		end else begin
			// result first: a command taken at the same edge cannot own it
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result with nothing owed: read_value %0d status %0d length_after %0d",
						read_value, status, length_after);
					errors = errors + 1;
				end else begin
					want = owed_results.pop_front();
					if (read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", want.rd, read_value);
						errors = errors + 1;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors = errors + 1;
					end
					if (length_after !== want.len) begin
						$error("length_after: expected %0d, got %0d", want.len, length_after);
						errors = errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				owed_results.push_back(apply_command(cmd, position, item_value));
		end
		pending <= owed_results.size();
		list_len <= entries.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the ordered list. Checking lives in list_checker.
module testbench;
	import ilo_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int LEN_W = $clog2(CAPACITY + 1);
	// command codes the block does not define
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LAST_UNUSED = 3'd7;
	// idle percentage per side
	localparam int IDLE_PCT = 20;
	// cycles with no transfer on either channel before giving up
	localparam int WATCHDOG_LIMIT = 2000;
	// result register depth is one; a few spare cycles catch stray results
	localparam int SETTLE_CYCLES = 8;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CMD_W-1:0]          cmd;
	logic [POS_W-1:0]          position;
	logic signed [DATA_W-1:0]  item_value;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  read_value;
	logic [ST_W-1:0]           status;
	logic [LEN_W-1:0]          length_after;

	int   errors;
	int   pending;   // results predicted but not yet transferred
	int   list_len;  // list length as the checker sees it, stable at the rising edge
	logic quiet;     // no idling on either side while set
	int   idle_cycles;

	indexed_ordered_list #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.status(status),
		.length_after(length_after)
	);

	list_checker #(.CAPACITY(CAPACITY)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.status(status),
		.length_after(length_after),
		.errors(errors),
		.pending(pending),
		.list_len(list_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side: random stalls unless a quiet stretch is running.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: any transfer restarts the count. Sampled mid-cycle, where
	// the handshake signals are settled.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the command transfers.
	// Random gaps go in front, so they fall after any kind of command.
	task automatic issue_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v);
		while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		position <= p;
		item_value <= v;
		// stall seen low mid-cycle means the transfer happens at the next edge
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Hold off the sender until every owed result has transferred.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// One random stretch. grow_pct and del_pct steer the list length: a high
	// insert share fills the list to capacity, a high delete share empties it.
	task automatic run_phase(input int count, input int grow_pct, input int del_pct);
		int                       roll;
		int                       len;
		logic [CMD_W-1:0]         c;
		logic [POS_W-1:0]         p;
		logic signed [DATA_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			len = list_len;
			roll = $urandom_range(99);
			if (roll < 2) begin
				c = $urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED);
			end else if (roll < 2 + grow_pct) begin
				case ($urandom_range(2))
					0:       c = CMD_INSERT;
					1:       c = CMD_HEAD;
					default: c = CMD_TAIL;
				endcase
			end else if (roll < 2 + grow_pct + del_pct) begin
				c = CMD_DELETE;
			end else begin
				c = CMD_GET;
			end
			// mostly in range; some anywhere in the field, some right at the end
			roll = $urandom_range(99);
			if (roll < 85)
				p = POS_W'($urandom_range(len));
			else if (roll < 95)
				p = POS_W'($urandom_range(255));
			else
				p = POS_W'(len);
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0:       v = 32'sh7FFF_FFFF;
					1:       v = 32'sh8000_0000;
					2:       v = -1;
					default: v = 0;
				endcase
			end else begin
				v = $urandom;
			end
			issue_command(c, p, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_GET;
		position = '0;
		item_value = '0;
		out_stall = 1'b0;
		quiet = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: everything on an empty list is out of range.
		issue_command(CMD_GET, 0, 0);
		issue_command(CMD_DELETE, 0, 0);
		issue_command(CMD_INSERT, 1, 11);
		issue_command(CMD_INSERT, 255, 12);
		// build [min, -1, 0x5a5aa5a5, max, 0] from both ends and the middle
		issue_command(CMD_TAIL, 0, 32'sh7FFF_FFFF);
		issue_command(CMD_HEAD, 0, 32'sh8000_0000);
		issue_command(CMD_INSERT, 1, -1);
		issue_command(CMD_INSERT, 3, 0);           // at the length: append
		issue_command(CMD_INSERT, 2, 32'sh5A5A_A5A5);
		for (int k = 0; k < 5; k++)
			issue_command(CMD_GET, POS_W'(k), 0);
		issue_command(CMD_GET, 5, 0);             // one past the end
		issue_command(CMD_GET, 255, 0);
		issue_command(CMD_DELETE, 4, 0);          // last entry
		issue_command(CMD_DELETE, 0, 0);          // first entry
		issue_command(CMD_DELETE, 3, 0);          // at the length: out of range
		// unused codes with every field bit set
		for (int k = CMD_FIRST_UNUSED; k <= CMD_LAST_UNUSED; k++)
			issue_command(CMD_W'(k), 255, -1);
		issue_command(CMD_GET, 1, 0);
		drain_results();

		// Random: fill to capacity and sit there, so full and range-on-full hit.
		run_phase(130, 80, 10);
		drain_results();
		// Empty it again with no idling on either side.
		quiet <= 1'b1;
		run_phase(130, 15, 55);
		drain_results();
		quiet <= 1'b0;
		run_phase(110, 80, 10);
		drain_results();
		run_phase(110, 40, 30);
		drain_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
